// File: rtl/modbus_rtu_response_checker_defines.svh
// assertion macros for the modbus rtu response checker
`ifndef MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define MBRC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MBRC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MBRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define MBRC_ASSERT_ALWAYS(lbl, cond, msg)
`define MBRC_ASSERT_IMPL(lbl, ante, cons, msg)
`define MBRC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/mbrc_pkg.sv
// shared constants, codes and crc function for the modbus rtu response checker
package mbrc_pkg;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int FUNC_W   = 2;
  localparam int COUNT_W  = 5;
  localparam int WORD_W   = 16;
  localparam int INDEX_W  = 5;
  localparam int STATUS_W = 3;

  // default frame length limit
  localparam int MAX_FRAME_BYTES_DEF = 64;

  // crc-16/modbus
  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

  // expected function selector
  localparam logic [FUNC_W-1:0] FUNC_READ_HOLDING = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_SINGLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_MULTI  = 2'd2;

  // function codes on the wire
  localparam logic [BYTE_W-1:0] CODE_READ_HOLDING = 8'h03;
  localparam logic [BYTE_W-1:0] CODE_WRITE_SINGLE = 8'h06;
  localparam logic [BYTE_W-1:0] CODE_WRITE_MULTI  = 8'h10;
  localparam logic [BYTE_W-1:0] CODE_NONE         = 8'h00;

  // frame status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_LENGTH = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_CRC    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD_ADDR   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_FUNC   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_BAD_COUNT  = 3'd5;

  // header fault bits
  localparam int FAULT_W     = 3;
  localparam int FAULT_ADDR  = 0;
  localparam int FAULT_FUNC  = 1;
  localparam int FAULT_COUNT = 2;

  // byte positions in the frame header
  localparam int POS_ADDR  = 0;
  localparam int POS_FUNC  = 1;
  localparam int POS_COUNT = 2;
  localparam int POS_DATA  = 3;

  // fixed length of a write response
  localparam int WRITE_FRAME_BYTES = 8;
  // header plus crc bytes of a read response
  localparam int READ_OVERHEAD_BYTES = 5;

  // one byte through the reflected crc, bit by bit
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] crc;
    crc = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // wire code of an expected function selector
  function automatic logic [BYTE_W-1:0] func_code(input logic [FUNC_W-1:0] sel);
    logic [BYTE_W-1:0] code;
    case (sel)
      FUNC_READ_HOLDING: code = CODE_READ_HOLDING;
      FUNC_WRITE_SINGLE: code = CODE_WRITE_SINGLE;
      FUNC_WRITE_MULTI:  code = CODE_WRITE_MULTI;
      default:           code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/mbrc_ifs.sv
// valid/ready channel interfaces for received bytes and checker results
interface mbrc_in_if;
  logic                         valid;
  logic                         ready;
  logic [mbrc_pkg::BYTE_W-1:0]  rx_byte;
  logic                         frame_end;
  logic [mbrc_pkg::FUNC_W-1:0]  expected_function;
  logic [mbrc_pkg::COUNT_W-1:0] expected_count;

  modport source (output valid, output rx_byte, output frame_end,
                  output expected_function, output expected_count, input ready);
  modport sink   (input valid, input rx_byte, input frame_end,
                  input expected_function, input expected_count, output ready);
endinterface

interface mbrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [mbrc_pkg::WORD_W-1:0]   word_value;
  logic [mbrc_pkg::INDEX_W-1:0]  word_index;
  logic                          word_valid;
  logic                          frame_done;
  logic [mbrc_pkg::STATUS_W-1:0] status;

  modport source (output valid, output word_value, output word_index,
                  output word_valid, output frame_done, output status, input ready);
  modport sink   (input valid, input word_value, input word_index,
                  input word_valid, input frame_done, input status, output ready);
endinterface

// File: rtl/modbus_rtu_response_checker.sv
// modbus rtu response checker: byte-wise frame checking, crc and data word extraction
//
// Received frame bytes enter on in_ch, one byte per transfer, with frame_end on
// the last byte; expected_function and expected_count are taken at the first
// byte of each frame. Results leave on out_ch: a word per completed big-endian
// data register of a read response, and on the last byte a status that gives
// the first failure among length, crc, slave address, function and byte count.
// A byte that completes a data word and ends the frame gives one result with
// both. The user must have the slave address register written through
// cfg_wr_en/cfg_wr_data only while no frame byte is in flight; the block does
// not enforce this. Each byte is held in an input register, checked and run
// through the crc in one pass, and its result lands in the output register that
// drives out_ch; one byte is taken every cycle while out_ch does not stall.
// When out_ch stalls, the held result keeps the byte in the input register and
// in_ch.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears the frame state (position 0, crc 0xFFFF) and sets the slave
// address to 1; the block takes bytes from the first cycle after reset.
module modbus_rtu_response_checker #(
  parameter int MAX_FRAME_BYTES = mbrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mbrc_pkg::BYTE_W-1:0] cfg_wr_data,
  mbrc_in_if.sink                     in_ch,
  mbrc_out_if.source                  out_ch
);
  import mbrc_pkg::*;

  `include "modbus_rtu_response_checker_defines.svh"

  // position counts up to one past the limit, then saturates
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
  // read frame lengths need seven bits; compares run at the wider of the two
  localparam int LEN_W = 7;
  localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

  // configuration
  logic [BYTE_W-1:0]   slave_addr_r;

  // input register
  logic                s1_valid_r;
  logic [BYTE_W-1:0]   s1_byte_r;
  logic                s1_last_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [COUNT_W-1:0]  s1_count_r;

  // frame state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [WORD_W-1:0]   crc_r, crc_nxt;
  logic [BYTE_W-1:0]   held_r, held_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [FAULT_W-1:0]  faults_r, faults_nxt;

  // output register
  logic                out_valid_r;
  logic [WORD_W-1:0]   word_value_r;
  logic [INDEX_W-1:0]  word_index_r;
  logic                word_valid_r;
  logic                frame_done_r;
  logic [STATUS_W-1:0] status_r;

  // per-byte results
  logic                out_free;
  logic                proc;
  logic                first_byte;
  logic                is_read;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    data_end;
  logic [CMP_W-1:0]    expected_len;
  logic [CMP_W-1:0]    total_len;
  logic [CMP_W-1:0]    word_off;
  logic [POS_W-1:0]    pos_inc;
  logic                in_data;
  logic                word_hit;
  logic [WORD_W-1:0]   word_value;
  logic [INDEX_W-1:0]  word_index;
  logic [STATUS_W-1:0] status;

  // handshake: the input register moves on only when the result slot is free
  assign out_free    = !out_valid_r || out_ch.ready;
  assign proc        = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || proc;

  // slave address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= BYTE_W'(1);
    end else if (cfg_wr_en) begin
      slave_addr_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r  <= in_ch.rx_byte;
      s1_last_r  <= in_ch.frame_end;
      s1_func_r  <= in_ch.expected_function;
      s1_count_r <= in_ch.expected_count;
    end
  end

  // byte check, crc step and word assembly
  always_comb begin
    first_byte = (pos_r == '0);
    func_nxt   = first_byte ? s1_func_r : func_r;
    count_nxt  = first_byte ? s1_count_r : count_r;
    is_read    = (func_nxt == FUNC_READ_HOLDING);
    pos_ext    = CMP_W'(pos_r);

    crc_nxt    = crc_byte(crc_r, s1_byte_r);

    // header checks
    faults_nxt = faults_r;
    if (pos_ext == CMP_W'(POS_ADDR) && s1_byte_r != slave_addr_r) begin
      faults_nxt[FAULT_ADDR] = 1'b1;
    end
    if (pos_ext == CMP_W'(POS_FUNC) && s1_byte_r != func_code(func_nxt)) begin
      faults_nxt[FAULT_FUNC] = 1'b1;
    end
    if (pos_ext == CMP_W'(POS_COUNT) && is_read &&
        s1_byte_r != BYTE_W'({count_nxt, 1'b0})) begin
      faults_nxt[FAULT_COUNT] = 1'b1;
    end

    // data area: odd positions hold the high byte, even ones complete a word
    data_end   = CMP_W'(POS_DATA) + CMP_W'({count_nxt, 1'b0});
    in_data    = is_read && (pos_ext >= CMP_W'(POS_DATA)) && (pos_ext < data_end);
    held_nxt   = held_r;
    word_hit   = 1'b0;
    if (in_data) begin
      if (pos_r[0]) begin
        held_nxt = s1_byte_r;
      end else begin
        word_hit = 1'b1;
      end
    end
    word_off   = (pos_ext - CMP_W'(POS_DATA + 1)) >> 1;
    word_value = word_hit ? {held_r, s1_byte_r} : '0;
    word_index = word_hit ? word_off[INDEX_W-1:0] : '0;

    // saturating byte position
    if (pos_r <= POS_W'(MAX_FRAME_BYTES)) begin
      pos_inc = POS_W'(pos_r + POS_W'(1));
    end else begin
      pos_inc = pos_r;
    end

    // frame status by priority
    total_len    = CMP_W'(pos_inc);
    expected_len = is_read ? CMP_W'(READ_OVERHEAD_BYTES) + CMP_W'({count_nxt, 1'b0})
                           : CMP_W'(WRITE_FRAME_BYTES);
    status = STAT_OK;
    if (s1_last_r) begin
      if (total_len > CMP_W'(MAX_FRAME_BYTES) || total_len != expected_len) begin
        status = STAT_BAD_LENGTH;
      end else if (crc_nxt != '0) begin
        status = STAT_BAD_CRC;
      end else if (faults_nxt[FAULT_ADDR]) begin
        status = STAT_BAD_ADDR;
      end else if (faults_nxt[FAULT_FUNC]) begin
        status = STAT_BAD_FUNC;
      end else if (faults_nxt[FAULT_COUNT]) begin
        status = STAT_BAD_COUNT;
      end
    end

    // frame end restarts the frame state
    pos_nxt = pos_inc;
    if (s1_last_r) begin
      pos_nxt    = '0;
      crc_nxt    = CRC_INIT;
      held_nxt   = '0;
      faults_nxt = '0;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
      held_r   <= '0;
      func_r   <= FUNC_READ_HOLDING;
      count_r  <= COUNT_W'(1);
      faults_r <= '0;
    end else if (proc) begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      held_r   <= held_nxt;
      func_r   <= func_nxt;
      count_r  <= count_nxt;
      faults_r <= faults_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= proc && (word_hit || s1_last_r);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      word_value_r <= word_value;
      word_index_r <= word_index;
      word_valid_r <= word_hit;
      frame_done_r <= s1_last_r;
      status_r     <= status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.word_value = word_value_r;
  assign out_ch.word_index = word_index_r;
  assign out_ch.word_valid = word_valid_r;
  assign out_ch.frame_done = frame_done_r;
  assign out_ch.status     = status_r;

  // checks
  `MBRC_ASSERT_IMPL(a_result_not_empty, out_valid_r, word_valid_r || frame_done_r, "empty result word")
  `MBRC_ASSERT_IMPL(a_status_only_at_end, out_valid_r && !frame_done_r, status_r == STAT_OK, "status outside frame end")
  `MBRC_ASSERT_NEXT(a_restart_after_end, proc && s1_last_r, pos_r == '0 && crc_r == CRC_INIT && faults_r == '0, "frame state not restarted")
  `MBRC_ASSERT_ALWAYS(a_pos_saturates, pos_r <= POS_W'(MAX_FRAME_BYTES + 1), "byte position past saturation")
  `MBRC_ASSERT_IMPL(a_word_on_even_pos, proc && word_hit, !pos_r[0] && is_read, "data word completed at odd position")

endmodule
